[rtl/ats_pkg.sv]
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants for the attribute text splitter.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int LEVEL_BITS_DEF = 8;

    // Parser phase codes
    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_COMMENT = 3'd1;
    localparam logic [2:0] PH_KEY     = 3'd2;
    localparam logic [2:0] PH_VALUE   = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Characters
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LSQ     = 8'h5B;
    localparam logic [7:0] CH_RSQ     = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] ch;
        logic       flag;
    } ats_result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_NL) || (b == CH_TAB);
    endfunction

endpackage

[rtl/ats_nest_track.sv]
// ----------------------------------------------------------------------------
// ats_nest_track
// Bracket and quote tracker: saturating nesting counters for [], {} and ()
// plus single/double quote toggles, updated for one byte.
// ----------------------------------------------------------------------------
module ats_nest_track
    import ats_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)
(
    input  logic [2:0][LEVEL_BITS-1:0] lv_in,
    input  logic [1:0]                 q_in,
    input  logic [7:0]                 b,
    output logic [2:0][LEVEL_BITS-1:0] lv_out,
    output logic [1:0]                 q_out,
    output logic                       top
);

    localparam logic [LEVEL_BITS-1:0] LVL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    localparam logic [LEVEL_BITS-1:0] LVL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};
    localparam logic [LEVEL_BITS-1:0] LVL_ONE = {{(LEVEL_BITS-1){1'b0}}, 1'b1};

    function automatic logic [LEVEL_BITS-1:0] bump_up(input logic [LEVEL_BITS-1:0] c);
        return (c == LVL_MAX) ? c : c + LVL_ONE;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] bump_dn(input logic [LEVEL_BITS-1:0] c);
        return (c == LVL_MIN) ? c : c - LVL_ONE;
    endfunction

    assign top = (lv_in[0] == '0) && (lv_in[1] == '0) && (lv_in[2] == '0)
                 && (q_in == 2'b00);

    always_comb
    begin
        lv_out = lv_in;
        q_out  = q_in;
        case (b)
            CH_LSQ:    lv_out[0] = bump_up(lv_in[0]);
            CH_RSQ:    lv_out[0] = bump_dn(lv_in[0]);
            CH_LBRACE: lv_out[1] = bump_up(lv_in[1]);
            CH_RBRACE: lv_out[1] = bump_dn(lv_in[1]);
            CH_LPAREN: lv_out[2] = bump_up(lv_in[2]);
            CH_RPAREN: lv_out[2] = bump_dn(lv_in[2]);
            CH_SQUOTE: q_out[0]  = ~q_in[0];
            CH_DQUOTE: q_out[1]  = ~q_in[1];
            default:   ;
        endcase
    end

endmodule

[rtl/ats_core.sv]
// ----------------------------------------------------------------------------
// ats_core
// Parser state and single-pass next-state / result logic for one byte.
// ----------------------------------------------------------------------------
module ats_core
    import ats_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output ats_result_t res
);

    logic [2:0]                 phase_reg, phase_next;
    logic [2:0][LEVEL_BITS-1:0] attr_lv_reg, attr_lv_next;
    logic [2:0][LEVEL_BITS-1:0] val_lv_reg, val_lv_next;
    logic [1:0]                 attr_q_reg, attr_q_next;
    logic [1:0]                 val_q_reg, val_q_next;
    logic                       key_seen_reg, key_seen_next;

    logic                       in_attr, start;
    logic [2:0]                 eff_phase;
    logic [2:0][LEVEL_BITS-1:0] eff_attr_lv, eff_val_lv, trk_attr_lv, trk_val_lv;
    logic [1:0]                 eff_attr_q, eff_val_q, trk_attr_q, trk_val_q;
    logic                       eff_key_seen, attr_top, val_top;

    always_comb
    begin
        in_attr = (phase_reg == PH_KEY) || (phase_reg == PH_VALUE)
                  || (phase_reg == PH_DONE);
        start   = !in_attr && (phase_reg != PH_COMMENT) && !is_ws(text_byte)
                  && (text_byte != CH_LSQ) && (text_byte != CH_RSQ)
                  && (text_byte != CH_SEMI) && (text_byte != CH_HASH);
    end

    // A new attribute starts from cleared trackers
    assign eff_phase    = start ? PH_KEY : phase_reg;
    assign eff_attr_lv  = start ? '0 : attr_lv_reg;
    assign eff_val_lv   = start ? '0 : val_lv_reg;
    assign eff_attr_q   = start ? 2'b00 : attr_q_reg;
    assign eff_val_q    = start ? 2'b00 : val_q_reg;
    assign eff_key_seen = start ? 1'b0 : key_seen_reg;

    ats_nest_track #(.LEVEL_BITS(LEVEL_BITS)) u_attr_track (
        .lv_in  (eff_attr_lv),
        .q_in   (eff_attr_q),
        .b      (text_byte),
        .lv_out (trk_attr_lv),
        .q_out  (trk_attr_q),
        .top    (attr_top)
    );

    ats_nest_track #(.LEVEL_BITS(LEVEL_BITS)) u_val_track (
        .lv_in  (eff_val_lv),
        .q_in   (eff_val_q),
        .b      (text_byte),
        .lv_out (trk_val_lv),
        .q_out  (trk_val_q),
        .top    (val_top)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        attr_lv_next  = attr_lv_reg;
        val_lv_next   = val_lv_reg;
        attr_q_next   = attr_q_reg;
        val_q_next    = val_q_reg;
        key_seen_next = key_seen_reg;
        res           = '0;

        if (end_of_text)
        begin
            if (in_attr)
            begin
                res.valid = 1'b1;
                res.kind  = KIND_END;
                res.flag  = key_seen_reg;
            end
            phase_next    = PH_BETWEEN;
            attr_lv_next  = '0;
            val_lv_next   = '0;
            attr_q_next   = 2'b00;
            val_q_next    = 2'b00;
            key_seen_next = 1'b0;
        end
        else if (phase_reg == PH_COMMENT)
        begin
            if (text_byte == CH_NL)
                phase_next = PH_BETWEEN;
        end
        else if (in_attr || start)
        begin
            if (text_byte == CH_SEMI && attr_top)
            begin
                res.valid     = 1'b1;
                res.kind      = KIND_END;
                res.flag      = eff_key_seen;
                phase_next    = PH_BETWEEN;
                attr_lv_next  = '0;
                val_lv_next   = '0;
                attr_q_next   = 2'b00;
                val_q_next    = 2'b00;
                key_seen_next = 1'b0;
            end
            else
            begin
                phase_next    = eff_phase;
                attr_lv_next  = trk_attr_lv;
                attr_q_next   = trk_attr_q;
                val_lv_next   = eff_val_lv;
                val_q_next    = eff_val_q;
                key_seen_next = eff_key_seen;
                if (eff_phase == PH_KEY)
                begin
                    if (text_byte == CH_EQ)
                        phase_next = PH_VALUE;
                    else if (!is_ws(text_byte))
                    begin
                        key_seen_next = 1'b1;
                        res.valid     = 1'b1;
                        res.kind      = KIND_KEY;
                        res.ch        = text_byte;
                    end
                end
                else if (eff_phase == PH_VALUE)
                begin
                    // top-level ';' ends the value, rest of attribute is swallowed
                    if (val_top && text_byte == CH_SEMI)
                        phase_next = PH_DONE;
                    else if (!(val_top && is_ws(text_byte)))
                    begin
                        val_lv_next = trk_val_lv;
                        val_q_next  = trk_val_q;
                        res.valid   = 1'b1;
                        res.kind    = KIND_VALUE;
                        res.ch      = text_byte;
                    end
                end
            end
        end
        else if (text_byte == CH_HASH)
            phase_next = PH_COMMENT;
        else
            phase_next = PH_BETWEEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_BETWEEN;
            attr_lv_reg  <= '0;
            val_lv_reg   <= '0;
            attr_q_reg   <= 2'b00;
            val_q_reg    <= 2'b00;
            key_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            attr_lv_reg  <= attr_lv_next;
            val_lv_reg   <= val_lv_next;
            attr_q_reg   <= attr_q_next;
            val_q_reg    <= val_q_next;
            key_seen_reg <= key_seen_next;
        end
    end

endmodule

[rtl/attribute_text_splitter.sv]
// ----------------------------------------------------------------------------
// attribute_text_splitter
// Streams key bytes, value bytes and one end marker per key = value attribute.
// ----------------------------------------------------------------------------
// One text byte per transaction in, at most one result per byte out. The
// block takes a byte every cycle unless the input stalls: a byte is
// registered on input, decoded combinationally against the parser state and
// its result lands in the output register. The input stalls only while a
// byte that yields a result finds the output register full and not being
// taken. Whitespace, square brackets and '#' comments between attributes,
// whitespace in keys and top-level whitespace in values produce no result.
// Nesting counters are LEVEL_BITS wide and saturate.
module attribute_text_splitter
    import ats_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] item_kind,
    output logic [7:0] char_out,
    output logic       store_flag
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  char_reg;
    logic        flag_reg;
    logic        advance;
    ats_result_t res;

    ats_core #(.LEVEL_BITS(LEVEL_BITS)) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .res         (res)
    );

    // silent bytes never wait on the output side
    assign advance  = in_valid_reg && (!res.valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            kind_reg <= res.kind;
            char_reg <= res.ch;
            flag_reg <= res.flag;
        end
    end

    assign out_valid  = out_valid_reg;
    assign item_kind  = kind_reg;
    assign char_out   = char_reg;
    assign store_flag = flag_reg;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (item_kind == KIND_KEY || item_kind == KIND_VALUE
                       || item_kind == KIND_END))
        else $error("illegal result kind");

    a_end_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && item_kind == KIND_END) |-> (char_out == 8'h00))
        else $error("end marker carries a character");

    a_byte_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && item_kind != KIND_END) |-> !store_flag)
        else $error("store flag set on a byte result");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(byte_reg)))
        else $error("stalled input byte lost");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (out_valid_reg && !out_ready && res.valid))
        else $error("input stalled without output back-pressure");

endmodule

[tb/sv/tb_attribute_text_splitter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_attribute_text_splitter
// Self-checking bench for the attribute text splitter. Text bytes are sent
// from a queue in random bursts. Each accepted transaction is run through a
// behavioural parser that predicts the key, value and end items. Results are
// checked in order while the output side stalls on its own random pattern,
// with one long hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_attribute_text_splitter;
    import ats_pkg::*;

    localparam int LVL_W       = LEVEL_BITS_DEF;
    localparam int RANDOM_ITEMS = 1350;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AFTER  = 400;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 10;

    localparam logic [LVL_W-1:0] LVL_TOP    = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic [LVL_W-1:0] LVL_BOTTOM = {1'b1, {(LVL_W-1){1'b0}}};
    localparam logic [LVL_W-1:0] LVL_STEP   = {{(LVL_W-1){1'b0}}, 1'b1};
    localparam logic [1:0]       Q_SINGLE   = 2'b01;
    localparam logic [1:0]       Q_DOUBLE   = 2'b10;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } text_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       flag;
    } split_item_t;

    typedef struct packed {
        logic [LVL_W-1:0] sq;
        logic [LVL_W-1:0] cu;
        logic [LVL_W-1:0] pa;
        logic [1:0]       quotes;
    } nest_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte   = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [1:0] item_kind;
    logic [7:0] char_out;
    logic       store_flag;

    text_item_t  pending_text[$];
    split_item_t split_due[$];

    // parser state mirrored by the predictor
    logic [2:0] parse_ph  = PH_BETWEEN;
    nest_t      attr_ctx  = '0;
    nest_t      val_ctx   = '0;
    logic       key_seen  = 1'b0;

    int  gap_left    = 0;
    int  burst_left  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    int  mode        = 0;
    int  mode_left   = 0;
    int  inputs_seen = 0;
    int  idle_cycles = 0;
    int  bad_count   = 0;
    bit  wind_down   = 1'b0;

    attribute_text_splitter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_kind   (item_kind),
        .char_out    (char_out),
        .store_flag  (store_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic nest_t track_nest(input nest_t n, input logic [7:0] b);
        nest_t r;
        r = n;
        case (b)
            CH_LSQ:    if (r.sq != LVL_TOP)    r.sq = r.sq + LVL_STEP;
            CH_RSQ:    if (r.sq != LVL_BOTTOM) r.sq = r.sq - LVL_STEP;
            CH_LBRACE: if (r.cu != LVL_TOP)    r.cu = r.cu + LVL_STEP;
            CH_RBRACE: if (r.cu != LVL_BOTTOM) r.cu = r.cu - LVL_STEP;
            CH_LPAREN: if (r.pa != LVL_TOP)    r.pa = r.pa + LVL_STEP;
            CH_RPAREN: if (r.pa != LVL_BOTTOM) r.pa = r.pa - LVL_STEP;
            CH_SQUOTE: r.quotes = r.quotes ^ Q_SINGLE;
            CH_DQUOTE: r.quotes = r.quotes ^ Q_DOUBLE;
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit at_top(input nest_t n);
        return n == '0;
    endfunction

    function automatic bit blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_NL) || (b == CH_TAB);
    endfunction

    function automatic void clear_split();
        parse_ph = PH_BETWEEN;
        attr_ctx = '0;
        val_ctx  = '0;
        key_seen = 1'b0;
    endfunction

    function automatic bit attr_byte(input logic [7:0] b, output split_item_t res);
        res = '0;
        if (b == CH_SEMI && at_top(attr_ctx))
        begin
            res.kind = KIND_END;
            res.flag = key_seen;
            clear_split();
            return 1'b1;
        end
        attr_ctx = track_nest(attr_ctx, b);
        if (parse_ph == PH_KEY)
        begin
            if (b == CH_EQ)
            begin
                parse_ph = PH_VALUE;
                return 1'b0;
            end
            if (blank(b))
                return 1'b0;
            key_seen = 1'b1;
            res.kind = KIND_KEY;
            res.ch   = b;
            return 1'b1;
        end
        if (parse_ph == PH_VALUE)
        begin
            if (at_top(val_ctx))
            begin
                if (b == CH_SEMI)
                begin
                    parse_ph = PH_DONE;
                    return 1'b0;
                end
                if (blank(b))
                    return 1'b0;
            end
            val_ctx  = track_nest(val_ctx, b);
            res.kind = KIND_VALUE;
            res.ch   = b;
            return 1'b1;
        end
        // rest of attribute after the value has closed: swallowed
        return 1'b0;
    endfunction

    function automatic bit split_predict(input logic [7:0] b, input logic eot,
                                         output split_item_t res);
        bit hit;
        hit = 1'b0;
        res = '0;
        if (eot)
        begin
            if (parse_ph == PH_KEY || parse_ph == PH_VALUE || parse_ph == PH_DONE)
            begin
                hit      = 1'b1;
                res.kind = KIND_END;
                res.flag = key_seen;
            end
            clear_split();
        end
        else
        begin
            case (parse_ph)
                PH_COMMENT:
                    if (b == CH_NL)
                        parse_ph = PH_BETWEEN;
                PH_KEY, PH_VALUE, PH_DONE:
                    hit = attr_byte(b, res);
                default:
                    if (blank(b) || b == CH_LSQ || b == CH_RSQ || b == CH_SEMI)
                        parse_ph = PH_BETWEEN;
                    else if (b == CH_HASH)
                        parse_ph = PH_COMMENT;
                    else
                    begin
                        clear_split();
                        parse_ph = PH_KEY;
                        hit = attr_byte(b, res);
                    end
            endcase
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        pending_text.insert(pending_text.size(), text_item_t'({b, 1'b0}));
    endtask

    task automatic push_eot(input logic [7:0] b);
        pending_text.insert(pending_text.size(), text_item_t'({b, 1'b1}));
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic push_deep_nest();
        push_byte("k");
        push_byte(CH_EQ);
        repeat ($urandom_range(120, 140)) push_byte(CH_LPAREN);
        repeat ($urandom_range(120, 140)) push_byte(CH_RPAREN);
        push_byte(CH_SEMI);
        push_byte("z");
        push_eot(8'($urandom_range(0, 255)));
    endtask

    task automatic push_value_token();
        int k;
        logic [7:0] q;
        string openers;
        string closers;
        openers = "[{(";
        closers = "]})";
        case ($urandom_range(0, 9))
            0, 1, 2, 3: push_byte(pick_from("abcxyzAZ019_.-+"));
            4: push_byte(pick_from(" \t\n"));
            5:
            begin
                k = $urandom_range(0, 2);
                push_byte(openers[k]);
                repeat ($urandom_range(0, 4)) push_byte(pick_from("a;= \t1"));
                push_byte(closers[k]);
            end
            6:
            begin
                q = pick_from("'\"");
                push_byte(q);
                repeat ($urandom_range(0, 4)) push_byte(pick_from("a;= \t1[)"));
                push_byte(q);
            end
            7: push_byte(CH_EQ);
            default: push_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic push_attribute();
        repeat ($urandom_range(0, 2)) push_byte(pick_from(" \t\n[]"));
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 8))
                7: push_byte(pick_from(" \t\n"));
                8: push_byte(8'($urandom_range(0, 255)));
                default: push_byte(pick_from("abkeyNAME_09"));
            endcase
        end
        if ($urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 1) != 0)
                push_byte(CH_SPACE);
            push_byte(CH_EQ);
            repeat ($urandom_range(0, 7)) push_value_token();
        end
        case ($urandom_range(0, 9))
            0: push_eot(8'($urandom_range(0, 255)));
            1: ;
            default: push_byte(CH_SEMI);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int base;
        int r;

        // directed: comment, stray ';', byte extremes with nesting and quotes,
        // empty key closed by end of text, value finished inside brackets
        push_str("#;\n");
        push_str(";");
        push_byte(8'h00);
        push_str("=(\";\")");
        push_byte(8'hFF);
        push_str(";");
        push_str("=");
        push_byte(8'h0D);
        push_eot(8'hFF);
        push_str("a[=b;c];");
        push_eot(8'h00);

        base = pending_text.size();
        push_deep_nest();
        while (pending_text.size() < base + RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                push_attribute();
            else if (r < 85)
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            else if (r < 91)
                push_eot(8'($urandom_range(0, 255)));
            else if (r < 98)
            begin
                push_byte(CH_HASH);
                repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)));
                push_byte(CH_NL);
            end
            else
                push_deep_nest();
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (pending_text.size() != 0 || in_valid)
            @(negedge clk);
        wind_down = 1'b1;
        while (split_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (bad_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        text_item_t nxt;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_text.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                nxt = pending_text.pop_front();
                in_valid    <= 1'b1;
                text_byte   <= nxt.b;
                end_of_text <= nxt.eot;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 80);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && inputs_seen >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (wind_down)
            out_ready <= 1'b1;
        else
        begin
            if (mode_left == 0)
            begin
                mode      <= $urandom_range(0, 2);
                mode_left <= $urandom_range(4, 60);
            end
            else
                mode_left <= mode_left - 1;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then predict from the input transaction
    // ------------------------------------------------------------------------
    task automatic flag_field(input string field, input int want, input int got);
        bad_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : observe
        split_item_t want;
        split_item_t got;
        split_item_t nxt;
        bit made;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {item_kind, char_out, store_flag};
                if (split_due.size() == 0)
                begin
                    bad_count++;
                    $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, got.kind, got.ch, got.flag);
                end
                else
                begin
                    want = split_due.pop_front();
                    if (got.kind != want.kind)
                        flag_field("item_kind", want.kind, got.kind);
                    if (got.ch != want.ch)
                        flag_field("char_out", want.ch, got.ch);
                    if (got.flag != want.flag)
                        flag_field("store_flag", want.flag, got.flag);
                end
            end
            if (in_valid && in_ready)
            begin
                made = split_predict(text_byte, end_of_text, nxt);
                if (made)
                    split_due.insert(split_due.size(), nxt);
                inputs_seen <= inputs_seen + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

[sim.f]
rtl/ats_pkg.sv
rtl/ats_nest_track.sv
rtl/ats_core.sv
rtl/attribute_text_splitter.sv
tb/sv/tb_attribute_text_splitter.sv
